// File: hdl/rraf_pkg.sv
// types and constants shared by the rounded rectangle fill pipeline
package rraf_pkg;

  localparam int PIX_W       = 12;
  localparam int CH_W        = 8;
  localparam int RAD_W       = 12;
  localparam int SQ_W        = 2 * RAD_W;
  localparam int REM_W       = RAD_W + 2;
  localparam int FRONT_STAGES = 5;
  localparam int ROOT_STAGES  = RAD_W;
  localparam int BACK_STAGES  = 3;
  localparam int N_STAGES     = FRONT_STAGES + ROOT_STAGES + BACK_STAGES;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_COLOR,
    REG_FILL_ALPHA,
    REG_RECT_LR,
    REG_RECT_TB,
    REG_CORNER_RADIUS,
    REG_CLIP_LR,
    REG_CLIP_TB,
    REG_CLIP_ENABLE
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0]      fill_color;
    logic [CH_W-1:0]  fill_alpha;
    logic [31:0]      rect_lr;
    logic [31:0]      rect_tb;
    logic [RAD_W-1:0] corner_radius;
    logic [31:0]      clip_lr;
    logic [31:0]      clip_tb;
    logic             clip_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fill_color:    24'd0,
    fill_alpha:    8'd255,
    rect_lr:       32'd0,
    rect_tb:       32'd0,
    corner_radius: 12'd0,
    clip_lr:       32'd0,
    clip_tb:       32'd0,
    clip_enable:   1'b0
  };

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
  } dst_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic             row_ok;
    logic [RAD_W-1:0] r;
    dst_t             dst;
  } ctx_t;

  typedef struct packed {
    ctx_t            ctx;
    logic [SQ_W-1:0] rad;
  } root_job_t;

  typedef struct packed {
    ctx_t             ctx;
    logic [RAD_W-1:0] root;
  } root_res_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_alpha;
    logic            covered;
  } result_t;

endpackage

// File: hdl/rraf_if.sv
// pixel stream interfaces: canvas pixels in, blended pixels out
interface rraf_in_if import rraf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic [CH_W-1:0]  dst_blue;
  logic [CH_W-1:0]  dst_green;
  logic [CH_W-1:0]  dst_red;
  logic [CH_W-1:0]  dst_alpha;

  modport source (output valid, pixel_x, pixel_y, dst_blue, dst_green, dst_red, dst_alpha,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, dst_blue, dst_green, dst_red, dst_alpha,
                output ready);
endinterface

interface rraf_out_if import rraf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_alpha;
  logic            covered;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, covered,
                  input ready);
  modport sink (input valid, out_blue, out_green, out_red, out_alpha, covered,
                output ready);
endinterface

// File: hdl/rraf_front.sv
// row test, radius clamp, corner row offset and squared radicand
module rraf_front import rraf_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic [PIX_W-1:0] in_x,
  input  logic [PIX_W-1:0] in_y,
  input  dst_t             in_dst,
  output root_job_t        job
);

  localparam logic [16:0] DIM_LIM = 17'(MAX_DIM);

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    dst_t             dst;
    logic             row_ok;
    logic [14:0]      half_w;
    logic [14:0]      half_h;
  } s1_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    dst_t             dst;
    logic             row_ok;
    logic [RAD_W-1:0] r;
  } s2_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    dst_t             dst;
    logic             row_ok;
    logic [RAD_W-1:0] r;
    logic [RAD_W-1:0] dy;
  } s3_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    dst_t             dst;
    logic             row_ok;
    logic [RAD_W-1:0] r;
    logic [SQ_W-1:0]  rr;
    logic [SQ_W-1:0]  dd;
  } s4_t;

  logic [15:0] l, rx, t, bx, ct, cb;
  logic [15:0] y16, w, h;
  logic [14:0] max_r;
  logic [16:0] y17, top_r, bot_r, diff_top, diff_bot;
  s1_t       s1, s1_next;
  s2_t       s2, s2_next;
  s3_t       s3, s3_next;
  s4_t       s4, s4_next;
  root_job_t job_next;

  assign l  = cfg.rect_lr[15:0];
  assign rx = cfg.rect_lr[31:16];
  assign t  = cfg.rect_tb[15:0];
  assign bx = cfg.rect_tb[31:16];
  assign ct = cfg.clip_tb[15:0];
  assign cb = cfg.clip_tb[31:16];

  // stage 1: row range and half sides
  always_comb begin
    y16 = 16'(in_y);
    w   = rx - l;
    h   = bx - t;
    s1_next.x      = in_x;
    s1_next.y      = in_y;
    s1_next.dst    = in_dst;
    s1_next.row_ok = (rx > l) && (y16 >= t) && (y16 < bx) && (17'(y16) < DIM_LIM) &&
                     (!cfg.clip_enable || ((y16 >= ct) && (y16 < cb)));
    s1_next.half_w = w[15:1];
    s1_next.half_h = h[15:1];
  end

  // stage 2: clamp radius
  always_comb begin
    max_r = (s1.half_w < s1.half_h) ? s1.half_w : s1.half_h;
    s2_next.x      = s1.x;
    s2_next.y      = s1.y;
    s2_next.dst    = s1.dst;
    s2_next.row_ok = s1.row_ok;
    s2_next.r      = (15'(cfg.corner_radius) > max_r) ? max_r[RAD_W-1:0] : cfg.corner_radius;
  end

  // stage 3: distance into a corner band
  always_comb begin
    y17      = 17'(s2.y);
    top_r    = 17'(t) + 17'(s2.r);
    bot_r    = 17'(bx) - 17'(s2.r);
    diff_top = top_r - y17;
    diff_bot = y17 + 17'(s2.r) + 17'd1 - 17'(bx);
    s3_next.x      = s2.x;
    s3_next.dst    = s2.dst;
    s3_next.row_ok = s2.row_ok;
    s3_next.r      = s2.r;
    if (y17 < top_r) begin
      s3_next.dy = diff_top[RAD_W-1:0];
    end else if (y17 >= bot_r) begin
      s3_next.dy = diff_bot[RAD_W-1:0];
    end else begin
      s3_next.dy = '0;
    end
  end

  // stage 4: squares
  always_comb begin
    s4_next.x      = s3.x;
    s4_next.dst    = s3.dst;
    s4_next.row_ok = s3.row_ok;
    s4_next.r      = s3.r;
    s4_next.rr     = s3.r * s3.r;
    s4_next.dd     = s3.dy * s3.dy;
  end

  // stage 5: radicand
  always_comb begin
    job_next.ctx.x      = s4.x;
    job_next.ctx.row_ok = s4.row_ok;
    job_next.ctx.r      = s4.r;
    job_next.ctx.dst    = s4.dst;
    job_next.rad        = s4.rr - s4.dd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= s1_next;
      s2  <= s2_next;
      s3  <= s3_next;
      s4  <= s4_next;
      job <= job_next;
    end
  end

endmodule

// File: hdl/rraf_sqrt.sv
// pipelined floor square root, one result bit per stage
module rraf_sqrt import rraf_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  root_job_t job,
  output root_res_t res
);

  typedef struct packed {
    logic [SQ_W-1:0]  rad;
    logic [REM_W-1:0] rem;
    logic [RAD_W-1:0] root;
    ctx_t             ctx;
  } sq_t;

  sq_t              st     [ROOT_STAGES];
  sq_t              src    [ROOT_STAGES];
  sq_t              nx     [ROOT_STAGES];
  logic [REM_W+1:0] rem_sh [ROOT_STAGES];
  logic [REM_W+1:0] trial  [ROOT_STAGES];
  logic [REM_W+1:0] diff   [ROOT_STAGES];
  logic             ge     [ROOT_STAGES];

  always_comb begin
    src[0].rad  = job.rad;
    src[0].rem  = '0;
    src[0].root = '0;
    src[0].ctx  = job.ctx;
    for (int i = 1; i < ROOT_STAGES; i++) begin
      src[i] = st[i-1];
    end
    for (int i = 0; i < ROOT_STAGES; i++) begin
      rem_sh[i]   = {src[i].rem, src[i].rad[SQ_W-1 -: 2]};
      trial[i]    = {2'b00, src[i].root, 2'b01};
      diff[i]     = rem_sh[i] - trial[i];
      ge[i]       = rem_sh[i] >= trial[i];
      nx[i].rad   = {src[i].rad[SQ_W-3:0], 2'b00};
      nx[i].rem   = ge[i] ? diff[i][REM_W-1:0] : rem_sh[i][REM_W-1:0];
      nx[i].root  = {src[i].root[RAD_W-2:0], ge[i]};
      nx[i].ctx   = src[i].ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ROOT_STAGES; i++) begin
        st[i] <= nx[i];
      end
    end
  end

  assign res.ctx  = st[ROOT_STAGES-1].ctx;
  assign res.root = st[ROOT_STAGES-1].root;

endmodule

// File: hdl/rraf_blend.sv
// row span, coverage test and source-over blend
module rraf_blend import rraf_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic      clk,
  input  logic      en,
  input  cfg_t      cfg,
  input  root_res_t rr_in,
  output result_t   res
);

  localparam logic signed [17:0] DIM_MAX_X = 18'(MAX_DIM - 1);

  typedef struct packed {
    logic [PIX_W-1:0]   x;
    dst_t               dst;
    logic               row_ok;
    logic [16:0]        x0;
    logic signed [17:0] x1;
  } s18_t;

  typedef struct packed {
    logic [PIX_W-1:0]   x;
    dst_t               dst;
    logic               row_ok;
    logic [16:0]        lo;
    logic signed [17:0] hi;
    logic [15:0]        cb_a;
    logic [15:0]        cg_a;
    logic [15:0]        cr_a;
    logic [15:0]        db_i;
    logic [15:0]        dg_i;
    logic [15:0]        dr_i;
    logic [15:0]        da_i;
  } s19_t;

  s18_t               s18, s18_next;
  s19_t               s19, s19_next;
  result_t            res_next;
  logic [RAD_W-1:0]   inset;
  logic [16:0]        clip_l;
  logic signed [17:0] x1_s, hi_a, cr_m1, hi_s, x_s;
  logic [CH_W-1:0]    ia;
  logic [8:0]         v_b, v_g, v_r, v_a;
  logic               cov;

  function automatic logic [8:0] div255(input logic [16:0] t);
    logic [16:0] q;
    q = t + 17'd1 + (t >> 8);
    return q[16:8];
  endfunction

  function automatic logic [CH_W-1:0] sat8(input logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

  // stage 18: inset span
  always_comb begin
    inset = rr_in.ctx.r - rr_in.root;
    s18_next.x      = rr_in.ctx.x;
    s18_next.dst    = rr_in.ctx.dst;
    s18_next.row_ok = rr_in.ctx.row_ok;
    s18_next.x0     = 17'(cfg.rect_lr[15:0]) + 17'(inset);
    s18_next.x1     = $signed({2'b00, cfg.rect_lr[31:16]}) - 18'sd1 - $signed({6'b0, inset});
  end

  // stage 19: canvas and clip bounds, blend products
  always_comb begin
    clip_l = 17'(cfg.clip_lr[15:0]);
    x1_s   = s18.x1;
    cr_m1  = $signed({2'b00, cfg.clip_lr[31:16]}) - 18'sd1;
    hi_a   = (x1_s > DIM_MAX_X) ? DIM_MAX_X : x1_s;
    ia     = 8'd255 - cfg.fill_alpha;
    s19_next.x      = s18.x;
    s19_next.dst    = s18.dst;
    s19_next.row_ok = s18.row_ok;
    s19_next.lo     = (cfg.clip_enable && (clip_l > s18.x0)) ? clip_l : s18.x0;
    s19_next.hi     = (cfg.clip_enable && (cr_m1 < hi_a)) ? cr_m1 : hi_a;
    s19_next.cb_a   = cfg.fill_color[23:16] * cfg.fill_alpha;
    s19_next.cg_a   = cfg.fill_color[15:8] * cfg.fill_alpha;
    s19_next.cr_a   = cfg.fill_color[7:0] * cfg.fill_alpha;
    s19_next.db_i   = s18.dst.blue * ia;
    s19_next.dg_i   = s18.dst.green * ia;
    s19_next.dr_i   = s18.dst.red * ia;
    s19_next.da_i   = s18.dst.alpha * ia;
  end

  // stage 20: coverage and rounding divide by 255
  always_comb begin
    hi_s = s19.hi;
    x_s  = $signed({6'b0, s19.x});
    cov  = s19.row_ok && (17'(s19.x) >= s19.lo) && (x_s <= hi_s);
    v_b  = div255(17'(s19.cb_a) + 17'(s19.db_i) + 17'd127);
    v_g  = div255(17'(s19.cg_a) + 17'(s19.dg_i) + 17'd127);
    v_r  = div255(17'(s19.cr_a) + 17'(s19.dr_i) + 17'd127);
    v_a  = 9'(cfg.fill_alpha) + div255(17'(s19.da_i) + 17'd127);
    res_next.covered = cov;
    if (cov) begin
      res_next.out_blue  = sat8(v_b);
      res_next.out_green = sat8(v_g);
      res_next.out_red   = sat8(v_r);
      res_next.out_alpha = sat8(v_a);
    end else begin
      res_next.out_blue  = s19.dst.blue;
      res_next.out_green = s19.dst.green;
      res_next.out_red   = s19.dst.red;
      res_next.out_alpha = s19.dst.alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s18 <= s18_next;
      s19 <= s19_next;
      res <= res_next;
    end
  end

endmodule

// File: hdl/rounded_rect_alpha_fill_top.sv
// rounded rectangle fill: config registers, stage valids and output skid
// throughput: one pixel per clock; the 20-stage pipeline and its 12-stage square root
// advance together and hold only while the skid register is occupied
// reset: synchronous, clears all valids (stage, output and skid valids) and the config
// registers (fill alpha to 255, others to 0); no clearing pass, ready right after reset
module rounded_rect_alpha_fill_top import rraf_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rraf_in_if.sink               pix_in,
  rraf_out_if.source            pix_out
);

  cfg_t                cfg;
  logic [N_STAGES-1:0] v;
  logic                en, leave, ov, sv;
  dst_t                in_dst;
  root_job_t           job;
  root_res_t           root_res;
  result_t             res, odata, sdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILL_COLOR:    cfg.fill_color    <= cfg_wdata[23:0];
        REG_FILL_ALPHA:    cfg.fill_alpha    <= cfg_wdata[CH_W-1:0];
        REG_RECT_LR:       cfg.rect_lr       <= cfg_wdata;
        REG_RECT_TB:       cfg.rect_tb       <= cfg_wdata;
        REG_CORNER_RADIUS: cfg.corner_radius <= cfg_wdata[RAD_W-1:0];
        REG_CLIP_LR:       cfg.clip_lr       <= cfg_wdata;
        REG_CLIP_TB:       cfg.clip_tb       <= cfg_wdata;
        REG_CLIP_ENABLE:   cfg.clip_enable   <= cfg_wdata[0];
      endcase
    end
  end

  assign en           = !sv;
  assign leave        = en && v[N_STAGES-1];
  assign pix_in.ready = en;

  assign in_dst = '{
    blue:  pix_in.dst_blue,
    green: pix_in.dst_green,
    red:   pix_in.dst_red,
    alpha: pix_in.dst_alpha
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N_STAGES-2:0], pix_in.valid};
    end
  end

  rraf_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .in_x   (pix_in.pixel_x),
    .in_y   (pix_in.pixel_y),
    .in_dst (in_dst),
    .job    (job)
  );

  rraf_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .job (job),
    .res (root_res)
  );

  rraf_blend #(.MAX_DIM(MAX_DIM)) u_blend (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .rr_in (root_res),
    .res   (res)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (ov && pix_out.ready) begin
      if (sv) begin
        sv <= 1'b0;
      end else if (!leave) begin
        ov <= 1'b0;
      end
    end else if (!ov) begin
      ov <= leave;
    end else if (leave) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ov && pix_out.ready) begin
      if (sv) begin
        odata <= sdata;
      end else if (leave) begin
        odata <= res;
      end
    end else if (!ov) begin
      if (leave) begin
        odata <= res;
      end
    end else if (leave) begin
      sdata <= res;
    end
  end

  assign pix_out.valid     = ov;
  assign pix_out.out_blue  = odata.out_blue;
  assign pix_out.out_green = odata.out_green;
  assign pix_out.out_red   = odata.out_red;
  assign pix_out.out_alpha = odata.out_alpha;
  assign pix_out.covered   = odata.covered;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> pix_out.valid)
    else $error("input stalled while output register empty");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> v[0])
    else $error("accepted beat missing from first stage");

  a_leave_lands: assert property (@(posedge clk) disable iff (rst)
    (v[N_STAGES-1] && en) |=> pix_out.valid)
    else $error("result leaving pipeline was dropped");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!pix_out.valid && pix_in.ready && (v == '0)))
    else $error("pipeline not clear after reset");
`endif

endmodule
